@@ sv/uart8_pkg.sv @@
// ----------------------------------------------------------------------------
// uart8_pkg
// Shared constants, codes and transaction structures for the 8N1 UART core
// with transmit and receive rings.
// ----------------------------------------------------------------------------
package uart8_pkg;

   localparam int TX_RING_DEPTH = 64;
   localparam int RX_RING_DEPTH = 64;
   localparam int DATA_BITS     = 8;

   localparam int TX_PTR_W  = $clog2(TX_RING_DEPTH);
   localparam int RX_PTR_W  = $clog2(RX_RING_DEPTH);
   localparam int BIT_SEL_W = $clog2(DATA_BITS);
   localparam int BIT_IDX_W = 4;
   localparam int PERIOD_W  = 15;
   localparam int COUNT_W   = 16;
   localparam int WAITING_W = 6;

   localparam logic [PERIOD_W-1:0]  BIT_PERIOD_RESET = 15'd208;
   localparam logic [COUNT_W-1:0]   TX_KICK_COUNT    = 16'd10;
   localparam logic [DATA_BITS-1:0] EMPTY_POP_DATA   = 8'hFF;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_PUSH = 2'd1,
      MODE_POP  = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      TXP_IDLE  = 4'b0001,
      TXP_START = 4'b0010,
      TXP_DATA  = 4'b0100,
      TXP_STOP  = 4'b1000
   } tx_phase_type;

   typedef enum logic [2:0] {
      RXP_WAIT = 3'b001,
      RXP_DATA = 3'b010,
      RXP_STOP = 3'b100
   } rx_phase_type;

   // Decoded transaction, strobes high only in the cycle of acceptance
   typedef struct packed {
      logic                 tick;
      logic                 push;
      logic                 pop;
      logic                 rx_line;
      logic [DATA_BITS-1:0] tx_data;
   } cmd_type;

   typedef struct packed {
      logic line;
      logic accepted;
   } tx_status_type;

   typedef struct packed {
      logic [WAITING_W-1:0] waiting;
      logic                 overrun;
      logic                 framing_error;
      logic                 pop_hit;
   } rx_status_type;

endpackage

@@ sv/uart8_ram.sv @@
// ----------------------------------------------------------------------------
// uart8_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module uart8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/uart8_tx.sv @@
// ----------------------------------------------------------------------------
// uart8_tx
// Transmit ring and 8N1 bit sequencer. The ring RAM read register doubles as
// the shift byte of the frame on the line.
// ----------------------------------------------------------------------------
module uart8_tx (
   input  logic                               clock,
   input  logic                               reset,
   input  uart8_pkg::cmd_type                 cmd,
   input  logic [uart8_pkg::PERIOD_W-1:0]     bit_period,
   output uart8_pkg::tx_status_type           status
);

   localparam int PTR_W = uart8_pkg::TX_PTR_W;

   uart8_pkg::tx_phase_type                 phase_ff, phase_in;
   logic                                    timer_on_ff, timer_on_in;
   logic [uart8_pkg::COUNT_W-1:0]           countdown_ff, countdown_in;
   logic [uart8_pkg::BIT_IDX_W-1:0]         bit_idx_ff, bit_idx_in;
   logic                                    level_ff, level_in;
   logic [PTR_W-1:0]                        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                        rd_ptr_ff, rd_ptr_in;

   logic [uart8_pkg::COUNT_W-1:0]           cd_dec;
   logic                                    cd_fire;
   logic [PTR_W-1:0]                        wr_next;
   logic [PTR_W-1:0]                        rd_next;
   logic                                    ram_wr, ram_rd, accepted;
   logic [uart8_pkg::DATA_BITS-1:0]         shift_byte;

   assign cd_dec  = countdown_ff - uart8_pkg::COUNT_W'(1);
   assign cd_fire = (cd_dec == '0);
   assign wr_next = (wr_ptr_ff == PTR_W'(uart8_pkg::TX_RING_DEPTH - 1)) ?
                    '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next = (rd_ptr_ff == PTR_W'(uart8_pkg::TX_RING_DEPTH - 1)) ?
                    '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      timer_on_in  = timer_on_ff;
      countdown_in = countdown_ff;
      bit_idx_in   = bit_idx_ff;
      level_in     = level_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      ram_wr       = 1'b0;
      ram_rd       = 1'b0;
      accepted     = 1'b0;

      if (cmd.tick && timer_on_ff) begin
         countdown_in = cd_fire ? uart8_pkg::COUNT_W'(bit_period) : cd_dec;
         if (cd_fire) begin
            unique case (phase_ff)
               uart8_pkg::TXP_START: begin
                  level_in   = 1'b0;
                  ram_rd     = 1'b1;
                  rd_ptr_in  = rd_next;
                  bit_idx_in = '0;
                  phase_in   = uart8_pkg::TXP_DATA;
               end
               uart8_pkg::TXP_DATA: begin
                  level_in   = shift_byte[bit_idx_ff[uart8_pkg::BIT_SEL_W-1:0]];
                  bit_idx_in = bit_idx_ff + uart8_pkg::BIT_IDX_W'(1);
                  if (bit_idx_in >= uart8_pkg::BIT_IDX_W'(uart8_pkg::DATA_BITS)) begin
                     phase_in = uart8_pkg::TXP_STOP;
                  end
               end
               uart8_pkg::TXP_STOP: begin
                  level_in = 1'b1;
                  phase_in = uart8_pkg::TXP_IDLE;
               end
               default: begin
                  // idle period over: next frame or stop the timer
                  if (wr_ptr_ff != rd_ptr_ff) begin
                     phase_in = uart8_pkg::TXP_START;
                  end else begin
                     timer_on_in = 1'b0;
                  end
               end
            endcase
         end
      end

      if (cmd.push && (wr_next != rd_ptr_ff)) begin
         ram_wr    = 1'b1;
         wr_ptr_in = wr_next;
         accepted  = 1'b1;
         if (phase_ff == uart8_pkg::TXP_IDLE) begin
            phase_in     = uart8_pkg::TXP_START;
            countdown_in = uart8_pkg::TX_KICK_COUNT;
            timer_on_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= uart8_pkg::TXP_IDLE;
         timer_on_ff  <= 1'b0;
         countdown_ff <= '0;
         bit_idx_ff   <= '0;
         level_ff     <= 1'b1;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         timer_on_ff  <= timer_on_in;
         countdown_ff <= countdown_in;
         bit_idx_ff   <= bit_idx_in;
         level_ff     <= level_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   uart8_ram #(
      .WIDTH (uart8_pkg::DATA_BITS),
      .DEPTH (uart8_pkg::TX_RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (cmd.tx_data),
      .rd_en   (ram_rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (shift_byte)
   );

   assign status.line     = level_in;
   assign status.accepted = accepted;

endmodule

@@ sv/uart8_rx.sv @@
// ----------------------------------------------------------------------------
// uart8_rx
// 8N1 receive sampler and receive ring. Pops read the ring RAM; the byte
// appears on rd_data in the next cycle and holds until the next pop that hits.
// ----------------------------------------------------------------------------
module uart8_rx (
   input  logic                               clock,
   input  logic                               reset,
   input  uart8_pkg::cmd_type                 cmd,
   input  logic [uart8_pkg::PERIOD_W-1:0]     bit_period,
   output uart8_pkg::rx_status_type           status,
   output logic [uart8_pkg::DATA_BITS-1:0]    rd_data
);

   localparam int PTR_W = uart8_pkg::RX_PTR_W;

   uart8_pkg::rx_phase_type                 phase_ff, phase_in;
   logic [uart8_pkg::COUNT_W-1:0]           countdown_ff, countdown_in;
   logic [uart8_pkg::DATA_BITS-1:0]         shift_ff, shift_in;
   logic [uart8_pkg::BIT_IDX_W-1:0]         bit_idx_ff, bit_idx_in;
   logic                                    prev_ff, prev_in;
   logic [PTR_W-1:0]                        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                        rd_ptr_ff, rd_ptr_in;

   logic [uart8_pkg::COUNT_W-1:0]           cd_dec;
   logic                                    cd_fire;
   logic [uart8_pkg::COUNT_W:0]             period_x3;
   logic [PTR_W-1:0]                        wr_next, rd_next;
   logic [PTR_W:0]                          count;
   logic                                    ram_wr, ram_rd;
   logic                                    overrun, framing_error, pop_hit;

   assign cd_dec    = countdown_ff - uart8_pkg::COUNT_W'(1);
   assign cd_fire   = (cd_dec == '0);
   assign period_x3 = {2'b00, bit_period} + {1'b0, bit_period, 1'b0};
   assign wr_next   = (wr_ptr_ff == PTR_W'(uart8_pkg::RX_RING_DEPTH - 1)) ?
                      '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next   = (rd_ptr_ff == PTR_W'(uart8_pkg::RX_RING_DEPTH - 1)) ?
                      '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      countdown_in  = countdown_ff;
      shift_in      = shift_ff;
      bit_idx_in    = bit_idx_ff;
      prev_in       = prev_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      ram_wr        = 1'b0;
      ram_rd        = 1'b0;
      overrun       = 1'b0;
      framing_error = 1'b0;
      pop_hit       = 1'b0;

      if (cmd.tick) begin
         prev_in = cmd.rx_line;
         if (phase_ff == uart8_pkg::RXP_WAIT) begin
            if (prev_ff && !cmd.rx_line) begin
               phase_in     = uart8_pkg::RXP_DATA;
               bit_idx_in   = '0;
               shift_in     = '0;
               countdown_in = period_x3[uart8_pkg::COUNT_W:1];
            end
         end else begin
            countdown_in = cd_fire ? uart8_pkg::COUNT_W'(bit_period) : cd_dec;
            if (cd_fire) begin
               unique case (phase_ff)
                  uart8_pkg::RXP_DATA: begin
                     if (cmd.rx_line) begin
                        shift_in[bit_idx_ff[uart8_pkg::BIT_SEL_W-1:0]] = 1'b1;
                     end
                     bit_idx_in = bit_idx_ff + uart8_pkg::BIT_IDX_W'(1);
                     if (bit_idx_in >= uart8_pkg::BIT_IDX_W'(uart8_pkg::DATA_BITS)) begin
                        phase_in = uart8_pkg::RXP_STOP;
                     end
                  end
                  uart8_pkg::RXP_STOP: begin
                     if (!cmd.rx_line) begin
                        framing_error = 1'b1;
                     end else if (wr_next == rd_ptr_ff) begin
                        overrun = 1'b1;
                     end else begin
                        ram_wr    = 1'b1;
                        wr_ptr_in = wr_next;
                     end
                     phase_in = uart8_pkg::RXP_WAIT;
                  end
                  default: begin
                     phase_in = uart8_pkg::RXP_WAIT;
                  end
               endcase
            end
         end
      end

      if (cmd.pop && (wr_ptr_ff != rd_ptr_ff)) begin
         ram_rd    = 1'b1;
         rd_ptr_in = rd_next;
         pop_hit   = 1'b1;
      end
   end

   // fill level after this transaction, modulo the ring depth
   always_comb begin
      count = {1'b0, wr_ptr_in} - {1'b0, rd_ptr_in};
      if (wr_ptr_in < rd_ptr_in) begin
         count = count + (PTR_W + 1)'(uart8_pkg::RX_RING_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= uart8_pkg::RXP_WAIT;
         countdown_ff <= '0;
         shift_ff     <= '0;
         bit_idx_ff   <= '0;
         prev_ff      <= 1'b1;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         shift_ff     <= shift_in;
         bit_idx_ff   <= bit_idx_in;
         prev_ff      <= prev_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   uart8_ram #(
      .WIDTH (uart8_pkg::DATA_BITS),
      .DEPTH (uart8_pkg::RX_RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (shift_ff),
      .rd_en   (ram_rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign status.waiting       = uart8_pkg::WAITING_W'(count);
   assign status.overrun       = overrun;
   assign status.framing_error = framing_error;
   assign status.pop_hit       = pop_hit;

endmodule

@@ sv/uart_8n1_with_fifos_core.sv @@
// ----------------------------------------------------------------------------
// uart_8n1_with_fifos_core
// 8N1 UART with transmit and receive rings behind a valid/ready request and
// response channel.
// ----------------------------------------------------------------------------
// A request transaction is a timer tick (carrying the sampled rx line), a
// push of one byte into the transmit ring or a pop from the receive ring;
// every request yields exactly one response transaction. The core takes one
// request per clock unless the response side stalls; stage one updates the
// bit timers and ring pointers and issues the ring RAM accesses of the
// transaction (a transmit ring read when a frame starts, a receive ring
// write when a good byte lands, a ring write on push or a ring read on pop),
// then stage two picks up the registered RAM read data into the response
// register. Each ring holds one byte fewer than its depth; a push to a full
// transmit ring is refused with tx_accepted low, and a byte arriving at a
// full receive ring is dropped and flagged as overrun. bit_period is to be
// written through the csr port only while the core is idle, which the core
// does not check; the first receive sample waits one and a half periods
// after the start edge. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module uart_8n1_with_fifos_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [uart8_pkg::PERIOD_W-1:0]       csr_wr_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic                                 req_rx_line,
   input  logic [uart8_pkg::DATA_BITS-1:0]      req_tx_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_tx_line,
   output logic [uart8_pkg::DATA_BITS-1:0]      rsp_rx_data,
   output logic                                 rsp_rx_data_valid,
   output logic [uart8_pkg::WAITING_W-1:0]      rsp_rx_waiting,
   output logic                                 rsp_tx_accepted,
   output logic                                 rsp_rx_overrun,
   output logic                                 rsp_rx_framing_error
);

   logic [uart8_pkg::PERIOD_W-1:0]   bit_period_ff;

   logic                             req_fire;
   uart8_pkg::cmd_type               cmd;
   uart8_pkg::tx_status_type         tx_status;
   uart8_pkg::rx_status_type         rx_status;
   logic [uart8_pkg::DATA_BITS-1:0]  rx_ram_data;

   // stage one: status of the transaction, waiting for the RAM read data
   logic                             p_valid_ff, p_valid_in;
   logic                             p_move;
   logic                             p_is_pop_ff;
   uart8_pkg::tx_status_type         p_tx_ff;
   uart8_pkg::rx_status_type         p_rx_ff;

   // stage two: response register
   logic                             o_valid_ff, o_valid_in;
   logic                             o_tx_line_ff;
   logic [uart8_pkg::DATA_BITS-1:0]  o_rx_data_ff;
   logic                             o_rx_data_valid_ff;
   logic [uart8_pkg::WAITING_W-1:0]  o_rx_waiting_ff;
   logic                             o_tx_accepted_ff;
   logic                             o_rx_overrun_ff;
   logic                             o_rx_framing_error_ff;

   // hold the bit period; writes only arrive while idle, by user rule alone
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= uart8_pkg::BIT_PERIOD_RESET;
      end else if (csr_wr_en) begin
         bit_period_ff <= csr_wr_data;
      end
   end

   // advance stage one when the response register is free or draining
   assign p_move    = p_valid_ff && (!o_valid_ff || rsp_ready);
   assign req_ready = !p_valid_ff || p_move;
   assign req_fire  = req_valid && req_ready;

   // decode the request; the unused mode code does nothing
   always_comb begin
      cmd         = '0;
      cmd.rx_line = req_rx_line;
      cmd.tx_data = req_tx_data;
      if (req_fire) begin
         unique case (uart8_pkg::mode_type'(req_mode))
            uart8_pkg::MODE_TICK: cmd.tick = 1'b1;
            uart8_pkg::MODE_PUSH: cmd.push = 1'b1;
            uart8_pkg::MODE_POP:  cmd.pop  = 1'b1;
            default:              cmd.tick = 1'b0;
         endcase
      end
   end

   uart8_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .bit_period (bit_period_ff),
      .status     (tx_status)
   );

   uart8_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .bit_period (bit_period_ff),
      .status     (rx_status),
      .rd_data    (rx_ram_data)
   );

   assign p_valid_in = req_fire || (p_valid_ff && !p_move);
   assign o_valid_in = p_move || (o_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // capture the transaction status on acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_is_pop_ff <= cmd.pop;
         p_tx_ff     <= tx_status;
         p_rx_ff     <= rx_status;
      end
   end

   // merge the ring read data; it holds until the next pop that hits
   always_ff @(posedge clock) begin
      if (p_move) begin
         o_tx_line_ff          <= p_tx_ff.line;
         o_tx_accepted_ff      <= p_tx_ff.accepted;
         o_rx_waiting_ff       <= p_rx_ff.waiting;
         o_rx_overrun_ff       <= p_rx_ff.overrun;
         o_rx_framing_error_ff <= p_rx_ff.framing_error;
         o_rx_data_valid_ff    <= p_rx_ff.pop_hit;
         if (!p_is_pop_ff) begin
            o_rx_data_ff <= '0;
         end else if (p_rx_ff.pop_hit) begin
            o_rx_data_ff <= rx_ram_data;
         end else begin
            o_rx_data_ff <= uart8_pkg::EMPTY_POP_DATA;
         end
      end
   end

   assign rsp_valid            = o_valid_ff;
   assign rsp_tx_line          = o_tx_line_ff;
   assign rsp_rx_data          = o_rx_data_ff;
   assign rsp_rx_data_valid    = o_rx_data_valid_ff;
   assign rsp_rx_waiting       = o_rx_waiting_ff;
   assign rsp_tx_accepted      = o_tx_accepted_ff;
   assign rsp_rx_overrun       = o_rx_overrun_ff;
   assign rsp_rx_framing_error = o_rx_framing_error_ff;

endmodule
